### sv/lsfa_pkg.sv
// Shared types, codes and constants of the scan frame assembler.
// Used by the controller, the datapath and the top level.
package lsfa_pkg;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_MAP    = 2'd2;
	localparam logic [1:0] OP_SPARE  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FRAME  = 3'd1;
	localparam logic [2:0] ST_BAD_ID = 3'd2;
	localparam logic [2:0] ST_ROT    = 3'd3;
	localparam logic [2:0] ST_ANGLE  = 3'd4;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_CENTER  = 2'd1;
	localparam logic [1:0] REG_COLUMNS = 2'd2;

	localparam logic [15:0] FULL_TURN = 16'd36000;
	localparam logic [15:0] HALF_TURN = 16'd18000;
	localparam logic [15:0] ID_LOWER  = 16'hEEFF;
	localparam logic [15:0] ID_UPPER  = 16'hDDFF;
	localparam logic [15:0] NO_ANGLE  = 16'hFFFF;
	localparam int BEAMS_PER_BLOCK = 32;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic exec;
		logic mod_step;
		logic copy_step;
		logic finish;
	} lsfa_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic copy_req;
		logic mod_done;
		logic copy_last;
		logic out_free;
	} lsfa_sts_t;

	function automatic logic angle_before(input logic [15:0] a, input logic [15:0] b);
		logic signed [17:0] d;
		d = $signed({2'b00, a}) - $signed({2'b00, b});
		if (d >= $signed({2'b00, HALF_TURN}))
			d = d - $signed({2'b00, FULL_TURN});
		if (d < -$signed({2'b00, HALF_TURN}))
			d = d + $signed({2'b00, FULL_TURN});
		return d < 0;
	endfunction

endpackage

### sv/lsfa_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lsfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### sv/lsfa_ctrl.sv
// Sequencing state machine of the scan frame assembler.
// Depends on lsfa_pkg; drives the datapath by command struct.
module lsfa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lsfa_pkg::lsfa_sts_t sts,
	output lsfa_pkg::lsfa_cmd_t cmd
);
	import lsfa_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_COPY  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE) && sts.out_free;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.accept = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = sts.copy_req ? S_MOD : S_IDLE;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done)
					state_d = S_COPY;
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end
endmodule

### sv/lsfa_dp.sv
// Datapath: item registers, trigger state, ring and frame stores, copy walk.
// Depends on lsfa_pkg and lsfa_ram.
module lsfa_dp #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_LASERS  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsfa_pkg::lsfa_cmd_t cmd,
	output lsfa_pkg::lsfa_sts_t sts,
	input  logic                lidar_mode,
	input  logic [15:0]         fov_center_angle,
	input  logic [9:0]          fov_columns,
	input  logic [1:0]          op,
	input  logic [15:0]         fire_id,
	input  logic [3:0]          block_index,
	input  logic [15:0]         rot_angle,
	input  logic [4:0]          beam,
	input  logic [15:0]         distance,
	input  logic                last_beam,
	input  logic [5:0]          laser_index,
	input  logic [5:0]          row,
	input  logic [8:0]          column,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [15:0]         read_data,
	output logic [31:0]         frame_count
);
	import lsfa_pkg::*;

	localparam int DEPTH = MAX_LASERS * MAX_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int WCW   = $clog2(MAX_COLUMNS);
	localparam int CCW   = ($clog2(MAX_COLUMNS + 1) > 10) ? $clog2(MAX_COLUMNS + 1) : 10;
	localparam int RW    = $clog2(MAX_LASERS);
	localparam logic [RW-1:0] ROWS_LAST_64 = RW'(MAX_LASERS - 1);
	localparam logic [RW-1:0] ROWS_LAST_32 = RW'(BEAMS_PER_BLOCK - 1);

	logic [1:0]  op_q;
	logic [15:0] id_q, rot_q, dist_q;
	logic [3:0]  bix_q;
	logic [4:0]  beam_q;
	logic        last_q, lsr_ok_q, rd_hit_q;

	logic [WCW-1:0] wc_q;
	logic [15:0]    prior_q, upair_q;
	logic           armed_q;
	logic [CCW-1:0] cl_q;
	logic [31:0]    frames_q;

	logic [CCW-1:0] start_q, src_q, ci_q;
	logic [RW-1:0]  cj_q, rows_last_q;
	logic           cp_we_s1;
	logic [AW-1:0]  cp_addr_s1;
	logic [AW-1:0]  clr_q;

	logic           out_valid_q;
	logic [2:0]     status_q;
	logic [15:0]    read_data_q;
	logic [31:0]    frame_count_q;

	logic [CCW-1:0] cols;
	logic [5:0]     lsr;
	logic [5:0]     map_rdata;
	logic [15:0]    ring_rdata, frame_rdata;
	logic           map_we, ring_we, frame_we;
	logic [AW-1:0]  ring_waddr, ring_raddr, frame_waddr, frame_raddr;
	logic [15:0]    ring_wdata, frame_wdata;

	logic           upper, row_ok;
	logic [4:0]     row32;
	logic [5:0]     row_sel;
	logic [2:0]     e_status;
	logic [15:0]    e_data;
	logic           ring_we_e, upd_upair, adv, arm_set, cl_dec, do_copy, load;
	logic [CCW-1:0] wc_inc, src_inc;

	always_comb begin
		cols = CCW'(fov_columns);
		if (cols < CCW'(2))
			cols = CCW'(2);
		if (cols > CCW'(MAX_COLUMNS))
			cols = CCW'(MAX_COLUMNS);
	end

	assign lsr = {lidar_mode & block_index[0], beam};
	assign map_we = cmd.accept && (op == OP_MAP) && ({1'b0, laser_index} < 7'(MAX_LASERS));

	lsfa_ram #(.WIDTH(6), .DEPTH(MAX_LASERS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (laser_index[RW-1:0]),
		.wdata (row),
		.raddr (lsr[RW-1:0]),
		.rdata (map_rdata)
	);

	assign upper = lidar_mode & bix_q[0];
	assign row32 = 5'd31 - ({beam_q[0], 4'b0000} + {1'b0, beam_q[4:1]});
	assign row_sel = lidar_mode ? map_rdata : {1'b0, row32};
	assign row_ok = !lidar_mode || (lsr_ok_q && ({1'b0, map_rdata} < 7'(MAX_LASERS)));

	always_comb begin
		e_status = ST_OK;
		e_data = '0;
		ring_we_e = 1'b0;
		upd_upair = 1'b0;
		adv = 1'b0;
		arm_set = 1'b0;
		cl_dec = 1'b0;
		do_copy = 1'b0;
		if (op_q == OP_SAMPLE) begin
			if (id_q != (upper ? ID_UPPER : ID_LOWER)) begin
				e_status = ST_BAD_ID;
			end else if (lidar_mode && bix_q[1]) begin
				e_status = (rot_q != prior_q) ? ST_ROT : ST_OK;
			end else if (upper && (rot_q != upair_q)) begin
				e_status = ST_ROT;
			end else begin
				ring_we_e = row_ok;
				if (lidar_mode && !upper) begin
					upd_upair = 1'b1;
				end else if (last_q) begin
					adv = 1'b1;
					if (!armed_q) begin
						if (prior_q != NO_ANGLE) begin
							if (prior_q >= FULL_TURN || fov_center_angle >= FULL_TURN) begin
								e_status = ST_ANGLE;
								adv = 1'b0;
							end else if (angle_before(prior_q, fov_center_angle)) begin
								if (rot_q >= FULL_TURN) begin
									e_status = ST_ANGLE;
									adv = 1'b0;
								end else if (!angle_before(rot_q, fov_center_angle)) begin
									arm_set = 1'b1;
								end
							end
						end
					end else if (cl_q <= CCW'(1)) begin
						do_copy = 1'b1;
						e_status = ST_FRAME;
					end else begin
						cl_dec = 1'b1;
					end
				end
			end
		end else if (op_q == OP_READ) begin
			e_data = rd_hit_q ? frame_rdata : 16'd0;
		end
	end

	assign wc_inc  = CCW'(wc_q) + CCW'(1);
	assign src_inc = src_q + CCW'(1);

	assign ring_we    = cmd.clr_step || (cmd.exec && ring_we_e);
	assign ring_waddr = cmd.clr_step ? clr_q
		: AW'(row_sel[RW-1:0]) * AW'(MAX_COLUMNS) + AW'(wc_q);
	assign ring_wdata = cmd.clr_step ? 16'd0 : dist_q;
	assign ring_raddr = AW'(cj_q) * AW'(MAX_COLUMNS) + AW'(src_q[WCW-1:0]);

	lsfa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	assign frame_we    = cmd.clr_step || cp_we_s1;
	assign frame_waddr = cmd.clr_step ? clr_q : cp_addr_s1;
	assign frame_wdata = cmd.clr_step ? 16'd0 : ring_rdata;
	assign frame_raddr = AW'(row[RW-1:0]) * AW'(MAX_COLUMNS) + AW'(column);

	lsfa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_waddr),
		.wdata (frame_wdata),
		.raddr (frame_raddr),
		.rdata (frame_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= op;
			id_q     <= fire_id;
			bix_q    <= block_index;
			rot_q    <= rot_angle;
			beam_q   <= beam;
			dist_q   <= distance;
			last_q   <= last_beam;
			lsr_ok_q <= {1'b0, lsr} < 7'(MAX_LASERS);
			rd_hit_q <= ({1'b0, row} < 7'(MAX_LASERS)) && (int'(column) < MAX_COLUMNS);
		end
		if (cmd.exec && do_copy) begin
			start_q     <= wc_inc;
			ci_q        <= '0;
			cj_q        <= '0;
			rows_last_q <= lidar_mode ? ROWS_LAST_64 : ROWS_LAST_32;
		end
		if (cmd.mod_step) begin
			if (!sts.mod_done)
				start_q <= start_q - cols;
			else
				src_q <= start_q;
		end
		if (cmd.copy_step) begin
			cp_addr_s1 <= AW'(cj_q) * AW'(MAX_COLUMNS) + AW'(ci_q[WCW-1:0]);
			if (ci_q == cols - CCW'(1)) begin
				ci_q  <= '0;
				cj_q  <= cj_q + RW'(1);
				src_q <= start_q;
			end else begin
				ci_q  <= ci_q + CCW'(1);
				src_q <= (src_inc == cols) ? '0 : src_inc;
			end
		end
		if (load) begin
			status_q      <= cmd.finish ? ST_FRAME : e_status;
			read_data_q   <= cmd.finish ? 16'd0 : e_data;
			frame_count_q <= frames_q;
		end
	end

	assign load = (cmd.exec && !do_copy) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q        <= '0;
			prior_q     <= NO_ANGLE;
			upair_q     <= NO_ANGLE;
			armed_q     <= 1'b0;
			cl_q        <= '0;
			frames_q    <= '0;
			clr_q       <= '0;
			cp_we_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cp_we_s1 <= cmd.copy_step;
			if (cmd.clr_step)
				clr_q <= clr_q + AW'(1);
			if (cmd.exec) begin
				if (upd_upair)
					upair_q <= rot_q;
				if (arm_set) begin
					armed_q <= 1'b1;
					cl_q    <= cols >> 1;
				end
				if (cl_dec)
					cl_q <= cl_q - CCW'(1);
				if (do_copy) begin
					cl_q     <= '0;
					armed_q  <= 1'b0;
					frames_q <= frames_q + 32'd1;
				end
				if (adv) begin
					prior_q <= rot_q;
					wc_q    <= (wc_inc >= cols) ? '0 : wc_q + WCW'(1);
				end
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.clr_last  = clr_q == AW'(DEPTH - 1);
	assign sts.copy_req  = do_copy;
	assign sts.mod_done  = start_q < cols;
	assign sts.copy_last = (ci_q == cols - CCW'(1)) && (cj_q == rows_last_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_data   = read_data_q;
	assign frame_count = frame_count_q;
endmodule

### sv/lidar_scan_frame_assembler_unit.sv
// Top level of the scan frame assembler: register port, controller, datapath.
// Depends on lsfa_pkg, lsfa_ctrl, lsfa_dp and lsfa_ram.
//
// Items enter on the in channel (valid/ready): laser return samples, frame
// reads and row map writes. Each item gives exactly one beat on the out
// channel: status, read data and the running frame count.
// An item is first accepted, which issues the store reads, and then executed
// against the registered read data. The result sits in an output register;
// the next item is taken in the cycle that result is taken.
// When a frame completes, the item also walks the start column into range
// (one subtraction of the column count a cycle) and copies the rotated ring
// into the frame store one element a cycle. The single store ports set
// this pace.
// After reset both stores are cleared, one entry a cycle over all
// MAX_LASERS x MAX_COLUMNS entries (32768 by default); no item is taken
// meanwhile, register writes are taken as ever.
// A stalled receiver holds the result beat and blocks further items.
// Registers sit at byte addresses 0 (mode), 4 (centre angle), 8 (columns);
// write them only while the block is idle.
module lidar_scan_frame_assembler_unit #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_LASERS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] fire_id,
	input  logic [3:0]  block_index,
	input  logic [15:0] rot_angle,
	input  logic [4:0]  beam,
	input  logic [15:0] distance,
	input  logic        last_beam,
	input  logic [5:0]  laser_index,
	input  logic [5:0]  row,
	input  logic [8:0]  column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] read_data,
	output logic [31:0] frame_count
);
	import lsfa_pkg::*;

	logic        mode_q;
	logic [15:0] center_q;
	logic [9:0]  columns_q;
	logic        wr;
	lsfa_cmd_t   cmd;
	lsfa_sts_t   sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			center_q  <= 16'd0;
			columns_q <= 10'd384;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_MODE:    mode_q    <= pwdata[0];
				REG_CENTER:  center_q  <= pwdata[15:0];
				REG_COLUMNS: columns_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:    prdata = {31'd0, mode_q};
			REG_CENTER:  prdata = {16'd0, center_q};
			REG_COLUMNS: prdata = {22'd0, columns_q};
			default:     prdata = 32'd0;
		endcase
	end

	lsfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsfa_dp #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_LASERS(MAX_LASERS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.lidar_mode       (mode_q),
		.fov_center_angle (center_q),
		.fov_columns      (columns_q),
		.op               (op),
		.fire_id          (fire_id),
		.block_index      (block_index),
		.rot_angle        (rot_angle),
		.beam             (beam),
		.distance         (distance),
		.last_beam        (last_beam),
		.laser_index      (laser_index),
		.row              (row),
		.column           (column),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.read_data        (read_data),
		.frame_count      (frame_count)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in work");

	a_out_free_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result register not free after accept");

	a_no_double_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.accept, cmd.exec, cmd.mod_step, cmd.copy_step,
			cmd.finish}))
		else $error("controller issued conflicting commands");
endmodule

### sim/lidar_scan_frame_assembler_unit_test.sv
// Self-checking testbench of lidar_scan_frame_assembler_unit: directed and random beats
// checked against a predictor of its own. Depends on lsfa_pkg and the unit.
module lidar_scan_frame_assembler_unit_test;
	import lsfa_pkg::*;

	localparam int NCOL = 512;
	localparam int NLAS = 64;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [2:0]  st;
		logic [15:0] data;
		logic [31:0] count;
	} frame_result_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] op;
	logic [15:0] fire_id, rot_angle, distance;
	logic [3:0] block_index;
	logic [4:0] beam;
	logic last_beam;
	logic [5:0] laser_index, row;
	logic [8:0] column;
	logic out_valid, out_ready;
	logic [2:0] status;
	logic [15:0] read_data;
	logic [31:0] frame_count;

	lidar_scan_frame_assembler_unit uut (.*);

	// predictor state
	logic        cfg_mode;
	logic [15:0] cfg_center;
	logic [9:0]  cfg_cols;
	logic [5:0]  map_mem [0:NLAS-1];
	logic [15:0] ring_mem [0:NLAS*NCOL-1];
	logic [15:0] frame_mem [0:NLAS*NCOL-1];
	int unsigned wcol, left_cols;
	logic [15:0] prior_ang, pair_ang;
	logic        armed;
	logic [31:0] frames_done;

	frame_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	int items_sent, stall_left;
	bit no_idle;
	int unsigned cur_ang;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bit ang_precedes(int a, int b);
		int d;
		d = a - b;
		if (d >= 18000) d -= 36000;
		if (d < -18000) d += 36000;
		return d < 0;
	endfunction

	function automatic int eff_cols();
		int c;
		c = int'(cfg_cols);
		if (c < 2) c = 2;
		if (c > NCOL) c = NCOL;
		return c;
	endfunction

	function automatic logic [2:0] predict_sample(logic [15:0] bid, logic [3:0] bix,
			logic [15:0] rot, logic [4:0] bm, logic [15:0] smp_dist, logic lst);
		bit upper;
		int r, cols, src;
		upper = cfg_mode && bix[0];
		cols = eff_cols();
		if (bid != (upper ? ID_UPPER : ID_LOWER)) return ST_BAD_ID;
		if (cfg_mode && bix[1]) return (rot != prior_ang) ? ST_ROT : ST_OK;
		if (upper && rot != pair_ang) return ST_ROT;
		if (cfg_mode) r = int'(map_mem[(upper ? 32 : 0) + int'(bm)]);
		else r = 31 - (int'(bm[0]) * 16 + int'(bm >> 1));
		ring_mem[r * NCOL + wcol] = smp_dist;
		if (cfg_mode && !upper) begin
			pair_ang = rot;
			return ST_OK;
		end
		if (!lst) return ST_OK;
		if (!armed) begin
			if (prior_ang != NO_ANGLE) begin
				if (prior_ang >= FULL_TURN || cfg_center >= FULL_TURN) return ST_ANGLE;
				if (ang_precedes(int'(prior_ang), int'(cfg_center))) begin
					if (rot >= FULL_TURN) return ST_ANGLE;
					if (!ang_precedes(int'(rot), int'(cfg_center))) begin
						armed = 1;
						left_cols = cols >> 1;
					end
				end
			end
		end else if (left_cols <= 1) begin
			left_cols = 0;
			for (int j = 0; j < (cfg_mode ? 64 : 32); j++)
				for (int i = 0; i < cols; i++) begin
					src = (i + wcol + 1) % cols;
					frame_mem[j * NCOL + i] = ring_mem[j * NCOL + src];
				end
			frames_done++;
			armed = 0;
			prior_ang = rot;
			wcol = (wcol + 1 >= cols) ? 0 : wcol + 1;
			return ST_FRAME;
		end else begin
			left_cols--;
		end
		prior_ang = rot;
		wcol = (wcol + 1 >= cols) ? 0 : wcol + 1;
		return ST_OK;
	endfunction

	function automatic int gap_len();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic [1:0] o, logic [15:0] bid, logic [3:0] bix,
			logic [15:0] rot, logic [4:0] bm, logic [15:0] dval, logic lst,
			logic [5:0] li, logic [5:0] rw, logic [8:0] col);
		frame_result_t res;
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			in_valid = 0;
			repeat (g) @(negedge clk);
		end
		op = o; fire_id = bid; block_index = bix; rot_angle = rot; beam = bm;
		distance = dval; last_beam = lst; laser_index = li; row = rw; column = col;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		res.st = ST_OK;
		res.data = '0;
		if (o == OP_SAMPLE) res.st = predict_sample(bid, bix, rot, bm, dval, lst);
		else if (o == OP_READ) res.data = frame_mem[int'(rw) * NCOL + int'(col)];
		else if (o == OP_MAP) map_mem[li] = rw;
		res.count = frames_done;
		pending_results.insert(pending_results.size(), res);
		items_sent++;
	endtask

	task automatic send_beat(logic [15:0] bid, logic [3:0] bix, logic [15:0] rot,
			logic [4:0] bm, logic lst);
		send_item(OP_SAMPLE, bid, bix, rot, bm, 16'($urandom), lst,
			6'($urandom), 6'($urandom), 9'($urandom));
	endtask

	task automatic send_read(logic [5:0] rw, logic [8:0] col);
		send_item(OP_READ, 16'($urandom), 4'($urandom), 16'($urandom), 5'($urandom),
			16'($urandom), 1'($urandom), 6'($urandom), rw, col);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (idx == REG_MODE) cfg_mode = val[0];
		else if (idx == REG_CENTER) cfg_center = val[15:0];
		else if (idx == REG_COLUMNS) cfg_cols = val[9:0];
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		frame_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected beat status", 32'(status), 32'd0);
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.st)
					report("status", 32'(status), 32'(exp_res.st));
				if (read_data !== exp_res.data)
					report("read_data", 32'(read_data), 32'(exp_res.data));
				if (frame_count !== exp_res.count)
					report("frame_count", frame_count, exp_res.count);
			end
		end
	end

	initial begin
		out_ready = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 0;
				stall_left--;
			end else begin
				out_ready = 1;
				if ($urandom_range(0, 99) < 15) stall_left = gap_len();
			end
		end
	end

	task automatic test_row_map();
		for (int l = 0; l < NLAS; l++)
			send_item(OP_MAP, '0, '0, '0, '0, '0, 1'b0, 6'(l),
				(l == 0) ? 6'd63 : (l == 1) ? 6'd0 : 6'($urandom), '0);
	endtask

	task automatic test_directed();
		send_item(OP_SPARE, 16'hFFFF, 4'hF, 16'hFFFF, 5'h1F, 16'hFFFF, 1'b1, 6'h3F, 6'h3F,
			9'h1FF);
		send_read(6'd63, 9'd511);
		send_read(6'd0, 9'd0);
		send_beat(16'h0000, 4'd0, 16'd100, 5'd0, 1'b0);
		send_beat(ID_LOWER, 4'd1, 16'd100, 5'd0, 1'b0);
		send_beat(ID_UPPER, 4'd1, 16'd500, 5'd3, 1'b1);
		send_item(OP_SAMPLE, ID_LOWER, 4'd0, 16'd100, 5'd0, 16'hFFFF, 1'b0, '0, '0, '0);
		send_item(OP_SAMPLE, ID_UPPER, 4'd1, 16'd100, 5'd31, 16'h0000, 1'b1, '0, '0, '0);
		send_beat(ID_LOWER, 4'd2, 16'd7, 5'd4, 1'b1);
		send_beat(ID_UPPER, 4'd3, 16'd100, 5'd4, 1'b1);
		wait_drained();
		write_reg(REG_CENTER, 32'hFFFF);
		send_beat(ID_LOWER, 4'd4, 16'd200, 5'd1, 1'b0);
		send_beat(ID_UPPER, 4'd5, 16'd200, 5'd1, 1'b1);
		wait_drained();
		write_reg(REG_CENTER, 32'd1000);
		send_beat(ID_LOWER, 4'd8, 16'd40000, 5'd2, 1'b0);
		send_beat(ID_UPPER, 4'd9, 16'd40000, 5'd2, 1'b1);
		send_beat(ID_LOWER, 4'd12, 16'd65535, 5'd2, 1'b1);
		wait_drained();
	endtask

	task automatic send_firing();
		int nb;
		logic [3:0] e;
		logic [15:0] rot;
		nb = $urandom_range(1, 3);
		cur_ang = (cur_ang + (($urandom_range(0, 9) == 0) ? 20000 : $urandom_range(50, 3000)))
			% 36000;
		rot = 16'(cur_ang);
		if (!cfg_mode) begin
			e = 4'($urandom);
			for (int b = 0; b < nb; b++)
				send_beat(ID_LOWER, e, rot, 5'($urandom), b == nb - 1);
		end else begin
			e = {2'($urandom), 2'b00};
			for (int b = 0; b < nb; b++)
				send_beat(ID_LOWER, e, rot, 5'($urandom), b == nb - 1);
			if ($urandom_range(0, 9) == 0) rot = rot + 16'd1;
			for (int b = 0; b < nb; b++)
				send_beat(ID_UPPER, e + 4'd1, rot, 5'($urandom), b == nb - 1);
			if ($urandom_range(0, 9) < 3)
				send_beat($urandom_range(0, 1) ? ID_LOWER : ID_UPPER, e + 4'd2, rot,
					5'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_phase(logic mode, logic [15:0] centre, logic [9:0] cols, int n);
		int stop, half;
		wait_drained();
		write_reg(REG_MODE, 32'(mode));
		write_reg(REG_CENTER, 32'(centre));
		write_reg(REG_COLUMNS, 32'(cols));
		no_idle = ($urandom_range(0, 3) == 0);
		stop = items_sent + n;
		half = items_sent + n / 2;
		while (items_sent < stop) begin
			if (items_sent >= half && half != 0) begin
				wait_drained();
				half = 0;
			end
			case ($urandom_range(0, 9))
				0: send_item(OP_SAMPLE, 16'($urandom), 4'($urandom), 16'($urandom),
					5'($urandom), 16'($urandom), 1'($urandom), 6'($urandom),
					6'($urandom), 9'($urandom));
				1: send_item(2'($urandom), 16'($urandom), 4'($urandom), 16'($urandom),
					5'($urandom), 16'($urandom), 1'($urandom), 6'($urandom),
					6'($urandom), 9'($urandom));
				2: send_read(6'($urandom), ($urandom_range(0, 3) == 0) ? 9'($urandom)
					: 9'($urandom_range(0, eff_cols() - 1)));
				default: send_firing();
			endcase
		end
		no_idle = 0;
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; op = OP_SAMPLE; fire_id = 0; block_index = 0; rot_angle = 0;
		beam = 0; distance = 0; last_beam = 0; laser_index = 0; row = 0; column = 0;
		cfg_mode = 1; cfg_center = 0; cfg_cols = 384;
		for (int k = 0; k < NLAS; k++) map_mem[k] = 0;
		for (int k = 0; k < NLAS * NCOL; k++) begin
			ring_mem[k] = 0;
			frame_mem[k] = 0;
		end
		wcol = 0; prior_ang = NO_ANGLE; pair_ang = NO_ANGLE; armed = 0; left_cols = 0;
		frames_done = 0; items_sent = 0; no_idle = 0;
		cur_ang = $urandom_range(0, 35999);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_row_map();
		test_directed();
		test_phase(1'b0, 16'd0, 10'd2, 120);
		test_phase(1'b1, 16'd35999, 10'd3, 120);
		test_phase(1'b0, 16'd18000, 10'd0, 100);
		test_phase(1'b1, 16'd9000, 10'd16, 120);
		test_phase(1'b0, 16'd27000, 10'd1023, 60);
		test_phase(1'b1, 16'd0, 10'd512, 40);
		test_phase(1'b0, 16'hFFFF, 10'd5, 60);
		test_phase(1'b1, 16'd300, 10'd33, 120);
		test_phase(1'b0, 16'd4500, 10'd9, 100);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

### filelist.f
sv/lsfa_pkg.sv
sv/lsfa_ram.sv
sv/lsfa_ctrl.sv
sv/lsfa_dp.sv
sv/lidar_scan_frame_assembler_unit.sv
sim/lidar_scan_frame_assembler_unit_test.sv
